// ===== src/scpa_pkg.sv =====
// Shared types and codes for the size-class pool allocator.
package scpa_pkg;

  localparam int SIZE_REGS = 4;
  localparam int APB_AW    = 6;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_STATS = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FIT     = 3'd1;
  localparam logic [2:0] ST_BAD_CLASS  = 3'd2;
  localparam logic [2:0] ST_STACK_FULL = 3'd3;
  localparam logic [2:0] ST_STATS_BAD  = 3'd4;

  localparam logic [2:0] REG_CLASS_COUNT  = 3'd0;
  localparam logic [2:0] REG_BLOCK_SIZE_0 = 3'd1;
  localparam logic [2:0] REG_BLOCK_SIZE_1 = 3'd2;
  localparam logic [2:0] REG_BLOCK_SIZE_2 = 3'd3;
  localparam logic [2:0] REG_BLOCK_SIZE_3 = 3'd4;
  localparam logic [2:0] REG_CAPACITIES   = 3'd5;

  typedef struct packed {
    logic [2:0]                  class_count;
    logic [SIZE_REGS-1:0][15:0]  blk_bytes;
    logic [63:0]                 capacities;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } cmd_t;

endpackage

// ===== src/size_class_pool_allocator_unit.sv =====
// Top level of the size-class pool allocator.
// An accepted request runs in EXEC, then waits in DATA until the output is free.
// A new request is taken only in IDLE or as DATA emits; the stack read is registered.
// A finished result waits in the output register while the next request is taken.
// Reset clears the configuration, the free counts and the output valid, so every class
// is empty; a defined-register write sets rebuild, reloading all counts and stacks.
module size_class_pool_allocator_unit #(
  parameter int NUM_CLASSES  = 4,
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [15:0]                  in_req_size,
  input  logic [1:0]                   in_class_sel,
  input  logic [7:0]                   in_block_sel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_status,
  output logic [1:0]                   out_granted_class,
  output logic [7:0]                   out_granted_block,
  output logic [15:0]                  out_class_block_size,
  output logic [8:0]                   out_class_capacity,
  output logic [8:0]                   out_used_blocks,
  output logic [8:0]                   out_free_blocks,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [scpa_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [63:0]                  cfg_pwdata,
  output logic [63:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import scpa_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic rebuild;

  scpa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .rebuild (rebuild)
  );

  scpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  scpa_dp #(
    .NUM_CLASSES  (NUM_CLASSES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg                  (cfg),
    .rebuild              (rebuild),
    .in_req_type          (in_req_type),
    .in_req_size          (in_req_size),
    .in_class_sel         (in_class_sel),
    .in_block_sel         (in_block_sel),
    .out_status           (out_status),
    .out_granted_class    (out_granted_class),
    .out_granted_block    (out_granted_block),
    .out_class_block_size (out_class_block_size),
    .out_class_capacity   (out_class_capacity),
    .out_used_blocks      (out_used_blocks),
    .out_free_blocks      (out_free_blocks)
  );

endmodule

// ===== src/scpa_regs.sv =====
// Configuration register file with APB-style access and stack rebuild request.
module scpa_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scpa_pkg::APB_AW-1:0]  paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  output scpa_pkg::cfg_t               cfg,
  output logic                         rebuild
);
  import scpa_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       rebuild_r, rebuild_nxt;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[APB_AW-1:3];

  always_comb begin
    cfg_nxt     = cfg_r;
    rebuild_nxt = 1'b0;
    if (wr) begin
      rebuild_nxt = 1'b1;
      case (idx)
        REG_CLASS_COUNT:  cfg_nxt.class_count  = pwdata[2:0];
        REG_BLOCK_SIZE_0: cfg_nxt.blk_bytes[0] = pwdata[15:0];
        REG_BLOCK_SIZE_1: cfg_nxt.blk_bytes[1] = pwdata[15:0];
        REG_BLOCK_SIZE_2: cfg_nxt.blk_bytes[2] = pwdata[15:0];
        REG_BLOCK_SIZE_3: cfg_nxt.blk_bytes[3] = pwdata[15:0];
        REG_CAPACITIES:   cfg_nxt.capacities   = pwdata;
        default:          rebuild_nxt          = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CLASS_COUNT:  prdata = 64'(cfg_r.class_count);
      REG_BLOCK_SIZE_0: prdata = 64'(cfg_r.blk_bytes[0]);
      REG_BLOCK_SIZE_1: prdata = 64'(cfg_r.blk_bytes[1]);
      REG_BLOCK_SIZE_2: prdata = 64'(cfg_r.blk_bytes[2]);
      REG_BLOCK_SIZE_3: prdata = 64'(cfg_r.blk_bytes[3]);
      REG_CAPACITIES:   prdata = cfg_r.capacities;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= '0;
      rebuild_r <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      rebuild_r <= rebuild_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign rebuild = rebuild_r;

endmodule

// ===== src/scpa_ctrl.sv =====
// Request sequencer: accept, execute against the stacks, deliver the result beat.
module scpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output scpa_pkg::cmd_t cmd
);
  import scpa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DATA} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_fire;

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    in_stall  = !((state_r == S_IDLE) || ((state_r == S_DATA) && out_free));
    in_fire   = in_valid && !in_stall;
    cmd.load  = in_fire;
    cmd.exec  = (state_r == S_EXEC);
    cmd.emit  = (state_r == S_DATA) && out_free;
    out_valid_nxt = cmd.emit || (out_valid_r && out_stall);
    case (state_r)
      S_IDLE:  state_nxt = in_fire ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_DATA;
      S_DATA: begin
        if (out_free) state_nxt = in_fire ? S_EXEC : S_IDLE;
        else          state_nxt = S_DATA;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/scpa_dp.sv =====
// Datapath: class fit search, free counts, free-list stack memory and result registers.
module scpa_dp #(
  parameter int NUM_CLASSES  = 4,
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  scpa_pkg::cmd_t cmd,
  input  scpa_pkg::cfg_t cfg,
  input  logic           rebuild,
  input  logic [1:0]     in_req_type,
  input  logic [15:0]    in_req_size,
  input  logic [1:0]     in_class_sel,
  input  logic [7:0]     in_block_sel,
  output logic [2:0]     out_status,
  output logic [1:0]     out_granted_class,
  output logic [7:0]     out_granted_block,
  output logic [15:0]    out_class_block_size,
  output logic [8:0]     out_class_capacity,
  output logic [8:0]     out_used_blocks,
  output logic [8:0]     out_free_blocks
);
  import scpa_pkg::*;

  localparam int PW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW     = $clog2(MAX_BLOCKS + 1);
  localparam int AW     = $clog2(SIZE_REGS) + PW;
  localparam int DEPTH  = SIZE_REGS << PW;
  localparam int NC_LIM = (NUM_CLASSES < SIZE_REGS) ? NUM_CLASSES : SIZE_REGS;
  localparam logic [16:0] MAXB = 17'(MAX_BLOCKS);
  localparam logic [16:0] HDR  = 17'(HEADER_BYTES);

  function automatic logic [CW-1:0] cap_of(logic [15:0] raw);
    if ({1'b0, raw} > MAXB) return CW'(MAX_BLOCKS);
    else                    return CW'(raw);
  endfunction

  function automatic logic [8:0] to9(logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[8:0];
  endfunction

  function automatic logic [7:0] to8(logic [PW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[7:0];
  endfunction

  // request hold
  logic [1:0]  req_type_r;
  logic [15:0] req_size_r;
  logic [1:0]  class_sel_r;
  logic [7:0]  block_sel_r;

  // per-class free count and low-water mark; stack entries at or above the
  // mark have been pushed since the last rebuild, entries below still hold
  // their own position
  logic [CW-1:0] count_r [SIZE_REGS];
  logic [CW-1:0] count_nxt [SIZE_REGS];
  logic [CW-1:0] low_r [SIZE_REGS];
  logic [CW-1:0] low_nxt [SIZE_REGS];
  logic [CW-1:0] cap [SIZE_REGS];

  logic [7:0]    stack_mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_addr;

  // staged result
  logic [2:0]  st_r, st_nxt;
  logic [1:0]  gcls_r, gcls_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        from_mem_r, from_mem_nxt;
  logic [15:0] bsize_r, bsize_nxt;
  logic [8:0]  capo_r, capo_nxt;
  logic [8:0]  used_r, used_nxt;
  logic [8:0]  freeo_r, freeo_nxt;

  logic [2:0]    n_act;
  logic [16:0]   need;
  logic          found;
  logic [1:0]    sel;
  logic [CW-1:0] pop_cnt;
  logic [PW-1:0] pop_pos;
  logic          cls_ok;
  logic [CW-1:0] cls_cnt;
  logic          cls_full;
  logic [PW-1:0] push_pos;

  always_comb begin
    for (int c = 0; c < SIZE_REGS; c++) begin
      cap[c] = cap_of(cfg.capacities[16*c +: 16]);
    end
    n_act = (cfg.class_count > 3'(NC_LIM)) ? 3'(NC_LIM) : cfg.class_count;
    need  = {1'b0, req_size_r} + HDR;
    found = 1'b0;
    sel   = 2'd0;
    for (int c = SIZE_REGS - 1; c >= 0; c--) begin
      if ((3'(c) < n_act) && ({1'b0, cfg.blk_bytes[c]} >= need) && (count_r[c] != '0)) begin
        found = 1'b1;
        sel   = 2'(c);
      end
    end
    pop_cnt  = count_r[sel] - CW'(1);
    pop_pos  = pop_cnt[PW-1:0];
    cls_ok   = {1'b0, class_sel_r} < n_act;
    cls_cnt  = count_r[class_sel_r];
    cls_full = cls_cnt >= cap[class_sel_r];
    push_pos = cls_cnt[PW-1:0];

    mem_re   = cmd.exec && (req_type_r == REQ_ALLOC) && found;
    mem_we   = cmd.exec && (req_type_r == REQ_FREE) && cls_ok && !cls_full;
    mem_addr = mem_we ? {class_sel_r, push_pos} : {sel, pop_pos};

    for (int c = 0; c < SIZE_REGS; c++) begin
      count_nxt[c] = count_r[c];
      low_nxt[c]   = low_r[c];
    end
    if (rebuild) begin
      for (int c = 0; c < SIZE_REGS; c++) begin
        count_nxt[c] = cap[c];
        low_nxt[c]   = cap[c];
      end
    end else if (mem_re) begin
      count_nxt[sel] = pop_cnt;
      if (pop_cnt < low_r[sel]) low_nxt[sel] = pop_cnt;
    end else if (mem_we) begin
      count_nxt[class_sel_r] = cls_cnt + CW'(1);
    end

    st_nxt       = ST_OK;
    gcls_nxt     = 2'd0;
    pos_nxt      = 8'd0;
    from_mem_nxt = 1'b0;
    bsize_nxt    = 16'd0;
    capo_nxt     = 9'd0;
    used_nxt     = 9'd0;
    freeo_nxt    = 9'd0;
    case (req_type_r)
      REQ_ALLOC: begin
        if (found) begin
          gcls_nxt     = sel;
          pos_nxt      = to8(pop_pos);
          from_mem_nxt = pop_cnt >= low_r[sel];
        end else begin
          st_nxt = ST_NO_FIT;
        end
      end
      REQ_FREE: begin
        if (!cls_ok)       st_nxt = ST_BAD_CLASS;
        else if (cls_full) st_nxt = ST_STACK_FULL;
      end
      REQ_STATS: begin
        if (!cls_ok) begin
          st_nxt = ST_STATS_BAD;
        end else begin
          bsize_nxt = cfg.blk_bytes[class_sel_r];
          capo_nxt  = to9(cap[class_sel_r]);
          used_nxt  = to9(cap[class_sel_r] - cls_cnt);
          freeo_nxt = to9(cls_cnt);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < SIZE_REGS; c++) begin
        count_r[c] <= '0;
        low_r[c]   <= '0;
      end
    end else begin
      for (int c = 0; c < SIZE_REGS; c++) begin
        count_r[c] <= count_nxt[c];
        low_r[c]   <= low_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_addr] <= block_sel_r;
    if (mem_re) rd_data_r <= stack_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r  <= in_req_type;
      req_size_r  <= in_req_size;
      class_sel_r <= in_class_sel;
      block_sel_r <= in_block_sel;
    end
    if (cmd.exec) begin
      st_r       <= st_nxt;
      gcls_r     <= gcls_nxt;
      pos_r      <= pos_nxt;
      from_mem_r <= from_mem_nxt;
      bsize_r    <= bsize_nxt;
      capo_r     <= capo_nxt;
      used_r     <= used_nxt;
      freeo_r    <= freeo_nxt;
    end
    if (cmd.emit) begin
      out_status           <= st_r;
      out_granted_class    <= gcls_r;
      out_granted_block    <= from_mem_r ? rd_data_r : pos_r;
      out_class_block_size <= bsize_r;
      out_class_capacity   <= capo_r;
      out_used_blocks      <= used_r;
      out_free_blocks      <= freeo_r;
    end
  end

endmodule

// ===== sim/size_class_pool_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the size-class pool allocator with its own pool predictor.
module size_class_pool_allocator_unit_test;
  import scpa_pkg::*;

  localparam int CLASSES = 4;
  localparam int BLOCKS  = 256;
  localparam int HDR     = 16;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  granted_class;
    logic [7:0]  granted_block;
    logic [15:0] class_block_size;
    logic [8:0]  class_capacity;
    logic [8:0]  used_blocks;
    logic [8:0]  free_blocks;
  } pool_reply_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] blk;
  } block_ref_t;

  logic        clk                  = 1'b0;
  logic        rst_n                = 1'b0;
  logic        in_valid             = 1'b0;
  logic [1:0]  in_req_type          = '0;
  logic [15:0] in_req_size          = '0;
  logic [1:0]  in_class_sel         = '0;
  logic [7:0]  in_block_sel         = '0;
  logic        out_stall            = 1'b0;
  logic        cfg_psel             = 1'b0;
  logic        cfg_penable          = 1'b0;
  logic        cfg_pwrite           = 1'b0;
  logic [APB_AW-1:0] cfg_paddr      = '0;
  logic [63:0] cfg_pwdata           = '0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [1:0]  out_granted_class;
  logic [7:0]  out_granted_block;
  logic [15:0] out_class_block_size;
  logic [8:0]  out_class_capacity;
  logic [8:0]  out_used_blocks;
  logic [8:0]  out_free_blocks;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  size_class_pool_allocator_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_req_size          (in_req_size),
    .in_class_sel         (in_class_sel),
    .in_block_sel         (in_block_sel),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_granted_class    (out_granted_class),
    .out_granted_block    (out_granted_block),
    .out_class_block_size (out_class_block_size),
    .out_class_capacity   (out_class_capacity),
    .out_used_blocks      (out_used_blocks),
    .out_free_blocks      (out_free_blocks),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pool predictor state
  logic [2:0]  cfg_count = '0;
  logic [15:0] cfg_bsize [CLASSES] = '{default: '0};
  logic [63:0] cfg_caps = '0;
  logic [7:0]  stack_mem [CLASSES][BLOCKS];
  logic [8:0]  free_cnt [CLASSES];

  pool_reply_t replies_due [$];
  block_ref_t  held_blocks [$];

  int mismatches = 0;
  int n_sent = 0, n_granted = 0, n_no_fit = 0, n_freed = 0, n_full = 0;
  int n_bad = 0, n_stats = 0, n_unused = 0, n_settings = 0;

  int burst_left  = 1;
  bit sender_gaps = 1'b1;

  int stall_pct    = 0;
  int stall_period = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int stall_cyc    = 0;

  function automatic int active_classes();
    return (cfg_count > CLASSES) ? CLASSES : int'(cfg_count);
  endfunction

  function automatic logic [8:0] capacity_of(int c);
    logic [15:0] raw;
    raw = cfg_caps[16*c +: 16];
    return (raw > BLOCKS) ? 9'(BLOCKS) : raw[8:0];
  endfunction

  function automatic void reload_pools();
    for (int c = 0; c < CLASSES; c++) begin
      for (int i = 0; i < BLOCKS; i++) stack_mem[c][i] = 8'(i);
      free_cnt[c] = capacity_of(c);
    end
    held_blocks.delete();
  endfunction

  function automatic pool_reply_t serve_request(logic [1:0] kind, logic [15:0] size,
                                                logic [1:0] cls, logic [7:0] blk);
    pool_reply_t r;
    int n;
    int need;
    bit done;
    r = '0;
    n = active_classes();
    need = int'(size) + HDR;
    done = 1'b0;
    case (kind)
      REQ_ALLOC: begin
        for (int c = 0; c < n && !done; c++) begin
          if (int'(cfg_bsize[c]) >= need && free_cnt[c] > 0) begin
            free_cnt[c]--;
            r.granted_class = 2'(c);
            r.granted_block = stack_mem[c][free_cnt[c]];
            held_blocks.push_back('{cls: 2'(c), blk: r.granted_block});
            done = 1'b1;
          end
        end
        r.status = done ? ST_OK : ST_NO_FIT;
        if (done) n_granted++;
        else n_no_fit++;
      end
      REQ_FREE: begin
        if (int'(cls) >= n) begin
          r.status = ST_BAD_CLASS;
          n_bad++;
        end else if (free_cnt[cls] >= capacity_of(cls)) begin
          r.status = ST_STACK_FULL;
          n_full++;
        end else begin
          stack_mem[cls][free_cnt[cls]] = blk;
          free_cnt[cls]++;
          n_freed++;
        end
      end
      REQ_STATS: begin
        n_stats++;
        if (int'(cls) >= n) begin
          r.status = ST_STATS_BAD;
          n_bad++;
        end else begin
          r.class_block_size = cfg_bsize[cls];
          r.class_capacity   = capacity_of(cls);
          r.used_blocks      = capacity_of(cls) - free_cnt[cls];
          r.free_blocks      = free_cnt[cls];
        end
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // receiver: long hold on request, else random and periodic stalls
  always @(posedge clk) begin
    stall_cyc++;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_period != 0 && stall_cyc % stall_period == 0) ||
                   ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    pool_reply_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0d", $time, out_status);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        compare_field("status", want.status, out_status);
        compare_field("granted_class", want.granted_class, out_granted_class);
        compare_field("granted_block", want.granted_block, out_granted_block);
        compare_field("class_block_size", want.class_block_size, out_class_block_size);
        compare_field("class_capacity", want.class_capacity, out_class_capacity);
        compare_field("used_blocks", want.used_blocks, out_used_blocks);
        compare_field("free_blocks", want.free_blocks, out_free_blocks);
      end
    end
  end

  task automatic send_request(logic [1:0] kind, logic [15:0] size, logic [1:0] cls,
                              logic [7:0] blk);
    int gap;
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_req_size  <= size;
    in_class_sel <= cls;
    in_block_sel <= blk;
    do @(posedge clk); while (in_stall);
    replies_due.push_back(serve_request(kind, size, cls, blk));
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      if (sender_gaps) begin
        gap = $urandom_range(1, 5);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CLASS_COUNT:  cfg_count = val[2:0];
      REG_BLOCK_SIZE_0: cfg_bsize[0] = val[15:0];
      REG_BLOCK_SIZE_1: cfg_bsize[1] = val[15:0];
      REG_BLOCK_SIZE_2: cfg_bsize[2] = val[15:0];
      REG_BLOCK_SIZE_3: cfg_bsize[3] = val[15:0];
      REG_CAPACITIES:   cfg_caps = val;
      default: ;
    endcase
    reload_pools();
    @(posedge clk);
  endtask

  task automatic set_pool(logic [2:0] count, logic [15:0] b0, b1, b2, b3, logic [63:0] caps);
    drain_replies();
    write_reg(REG_CLASS_COUNT, 64'(count));
    write_reg(REG_BLOCK_SIZE_0, 64'(b0));
    write_reg(REG_BLOCK_SIZE_1, 64'(b1));
    write_reg(REG_BLOCK_SIZE_2, 64'(b2));
    write_reg(REG_BLOCK_SIZE_3, 64'(b3));
    write_reg(REG_CAPACITIES, caps);
    n_settings++;
  endtask

  task automatic random_pool();
    logic [2:0]  count;
    logic [15:0] bs [CLASSES];
    logic [63:0] caps;
    int roll;
    count = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    for (int c = 0; c < CLASSES; c++) begin
      bs[c] = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(16, 440));
      roll = $urandom_range(9);
      caps[16*c +: 16] = (roll < 7) ? 16'($urandom_range(1, 6)) :
                         (roll < 9) ? 16'($urandom_range(256)) : 16'($urandom);
    end
    set_pool(count, bs[0], bs[1], bs[2], bs[3], caps);
  endtask

  task automatic random_request();
    int pick;
    int idx;
    block_ref_t victim;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_request(REQ_ALLOC,
                   ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(420)),
                   2'($urandom), 8'($urandom));
    end else if (pick < 75 && held_blocks.size() != 0) begin
      idx = $urandom_range(held_blocks.size() - 1);
      victim = held_blocks[idx];
      held_blocks.delete(idx);
      send_request(REQ_FREE, 16'($urandom), victim.cls, victim.blk);
    end else if (pick < 85) begin
      send_request(REQ_FREE, 16'($urandom), 2'($urandom), 8'($urandom));
    end else if (pick < 95) begin
      send_request(REQ_STATS, 16'($urandom), 2'($urandom), 8'($urandom));
    end else begin
      send_request(REQ_UNUSED, 16'($urandom), 2'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_reset_pool();
    send_request(REQ_ALLOC, 16'h0000, 2'd0, 8'h00);
    send_request(REQ_FREE, 16'h0000, 2'd0, 8'h00);
    send_request(REQ_STATS, 16'h0000, 2'd0, 8'h00);
    send_request(REQ_UNUSED, 16'hFFFF, 2'd3, 8'hFF);
  endtask

  task automatic test_directed_edges();
    set_pool(3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_ALLOC, 16'h0000, 2'd0, 8'h00);
    set_pool(3'd7, 16'd32, 16'd64, 16'hFFFF, 16'd0, {16'd3, 16'hFFFF, 16'd256, 16'd2});
    send_request(REQ_ALLOC, 16'd0, 2'd0, 8'h00);
    send_request(REQ_ALLOC, 16'd16, 2'd0, 8'h00);
    send_request(REQ_ALLOC, 16'd16, 2'd0, 8'h00);
    send_request(REQ_ALLOC, 16'hFFFF, 2'd0, 8'h00);
    send_request(REQ_ALLOC, 16'd65519, 2'd0, 8'h00);
    send_request(REQ_ALLOC, 16'd48, 2'd0, 8'h00);
    send_request(REQ_STATS, 16'd0, 2'd0, 8'h00);
    send_request(REQ_STATS, 16'd0, 2'd2, 8'h00);
    send_request(REQ_FREE, 16'd0, 2'd0, 8'd200);
    send_request(REQ_FREE, 16'd0, 2'd0, 8'd1);
    send_request(REQ_FREE, 16'd0, 2'd0, 8'd5);
    send_request(REQ_FREE, 16'd0, 2'd3, 8'hFF);
    send_request(REQ_ALLOC, 16'd0, 2'd0, 8'h00);
    send_request(REQ_STATS, 16'd0, 2'd3, 8'h00);
    send_request(REQ_UNUSED, 16'h5A5A, 2'd1, 8'hA5);
    set_pool(3'd2, 16'hFFFF, 16'd20, 16'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_STATS, 16'd0, 2'd3, 8'h00);
    send_request(REQ_FREE, 16'd0, 2'd2, 8'h00);
    send_request(REQ_ALLOC, 16'd4, 2'd0, 8'h00);
    send_request(REQ_STATS, 16'd0, 2'd1, 8'h00);
    send_request(REQ_FREE, 16'd0, 2'd1, 8'h00);
  endtask

  task automatic test_backpressure();
    set_pool(3'd4, 16'd64, 16'd128, 16'd256, 16'd512, {16'd8, 16'd8, 16'd8, 16'd8});
    stall_pct    = 0;
    stall_period = 0;
    sender_gaps  = 1'b0;
    repeat (20) random_request();
    hold_reqs++;
    repeat (40) random_request();
    drain_replies();
    sender_gaps = 1'b1;
    stall_pct   = 30;
    repeat (20) random_request();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      random_pool();
      stall_pct    = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
      stall_period = (phase % 2 == 0) ? $urandom_range(2, 5) : 0;
      sender_gaps  = (phase != 3);
      repeat (90) random_request();
    end
  endtask

  initial begin
    reload_pools();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_pool();
    test_directed_edges();
    test_backpressure();
    test_random_traffic();
    drain_replies();
    $display("covered %0d requests over %0d pool settings: %0d grants, %0d no-fit, %0d frees",
             n_sent, n_settings, n_granted, n_no_fit, n_freed);
    $display("full-stack frees %0d, bad-class replies %0d, stats reads %0d, unused codes %0d",
             n_full, n_bad, n_stats, n_unused);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("size_class_pool_allocator_unit_test: done, clean");
    end else begin
      $display("size_class_pool_allocator_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("size_class_pool_allocator_unit_test: done, errors");
    $finish;
  end

endmodule
